// File: hw/rtl/dss_pkg.sv
// Shared types, constants and table functions of the drum step sequencer.
package dss_pkg;

  localparam int PATTERNS_DEF = 8;
  localparam int TRACKS_DEF   = 16;
  localparam int STEPS_DEF    = 16;

  localparam int STEP_W     = 4;
  localparam int ENABLE_POS = 3;

  localparam logic [3:0] CHANNEL_RST = 4'd0;
  localparam logic [4:0] TPS_RST     = 5'd6;
  localparam logic [6:0] TPB_RST     = 7'd24;
  localparam logic [4:0] BPM_RST     = 5'd4;
  localparam logic [7:0] DIVIDE_RST  = 8'd20;

  localparam logic [7:0] DIVIDER_MAX      = 8'd255;
  localparam logic [2:0] DEFAULT_VELOCITY = 3'd5;
  localparam logic [7:0] VELO_SCALE       = 8'd18;
  localparam logic [7:0] VELO_MAX         = 8'd127;
  localparam logic [3:0] BEAT_MAX         = 4'd15;

  typedef enum logic [3:0] {
    CMD_TIMER          = 4'd0,
    CMD_MIDI_CLOCK     = 4'd1,
    CMD_START          = 4'd2,
    CMD_STOP           = 4'd3,
    CMD_CONTINUE       = 4'd4,
    CMD_PLAY           = 4'd5,
    CMD_TOGGLE_STEP    = 4'd6,
    CMD_SET_VELOCITY   = 4'd7,
    CMD_TOGGLE_TRACK   = 4'd8,
    CMD_SELECT_PATTERN = 4'd9,
    CMD_JUMP           = 4'd10,
    CMD_CLEAR          = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CHANNEL             = 3'd0,
    REG_TICKS_PER_SIXTEENTH = 3'd1,
    REG_BEAT_TICKS          = 3'd2,
    REG_MEASURE_BEATS       = 3'd3,
    REG_INTERNAL_DIVIDE     = 3'd4
  } reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDIT,
    ST_MASK,
    ST_SCAN,
    ST_FLUSH
  } st_state_t;

  typedef enum logic [1:0] {
    TM_IDLE,
    TM_PHASE,
    TM_WRAP
  } tm_state_t;

  typedef struct packed {
    logic [3:0] chan;
    logic [4:0] ticks_per_sixteenth;
    logic [6:0] beat_ticks;
    logic [4:0] measure_beats;
    logic [7:0] internal_divide;
  } cfg_t;

  typedef struct packed {
    logic       start;
    cmd_t       op;
    logic [2:0] pattern;
    logic [3:0] track;
    logic [3:0] step;
    logic [2:0] velocity;
  } req_t;

  function automatic logic [6:0] note_of(input logic [3:0] trk);
    logic [6:0] n;
    unique case (trk)
      4'd0:    n = 7'd49;
      4'd1:    n = 7'd37;
      4'd2:    n = 7'd39;
      4'd3:    n = 7'd51;
      4'd4:    n = 7'd42;
      4'd5:    n = 7'd44;
      4'd6:    n = 7'd46;
      4'd7:    n = 7'd50;
      4'd8:    n = 7'd36;
      4'd9:    n = 7'd38;
      4'd10:   n = 7'd40;
      4'd11:   n = 7'd41;
      4'd12:   n = 7'd43;
      4'd13:   n = 7'd45;
      4'd14:   n = 7'd47;
      default: n = 7'd48;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] velocity_of(input logic [2:0] v);
    logic [7:0] x;
    x = 8'(v) * VELO_SCALE + 8'd1;
    return (x > VELO_MAX) ? VELO_MAX[6:0] : x[6:0];
  endfunction

endpackage

// File: hw/rtl/dss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dss_ram #(
  parameter int WIDTH = dss_pkg::STEP_W,
  parameter int DEPTH = dss_pkg::PATTERNS_DEF * dss_pkg::TRACKS_DEF * dss_pkg::STEPS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dss_rem.sv
// Restoring remainder unit: one dividend bit per cycle, eight dividend bits per request.
module dss_rem (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [6:0] divisor,
  output logic       done,
  output logic [6:0] rem
);

  localparam int ITER = 8;

  logic       busy;
  logic [2:0] cnt;
  logic [7:0] num;
  logic [6:0] den;
  logic [6:0] r;
  logic [7:0] shifted;
  logic [6:0] r_next;

  always_comb begin
    shifted = {r, num[7]};
    if (shifted >= {1'b0, den}) begin
      r_next = 7'(shifted - {1'b0, den});
    end else begin
      r_next = shifted[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 3'(ITER - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(ITER - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      r   <= '0;
    end else if (busy) begin
      num <= {num[6:0], 1'b0};
      r   <= r_next;
    end
  end

  assign rem = r;

endmodule

// File: hw/rtl/dss_timing.sv
// Transport state, clock divider and tick/beat/step counters of the sequencer.
module dss_timing #(
  parameter int PATTERNS = dss_pkg::PATTERNS_DEF,
  parameter int STEPS    = dss_pkg::STEPS_DEF,
  localparam int PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1,
  localparam int SW = $clog2(STEPS)
) (
  input  logic           clk,
  input  logic           rst,
  input  dss_pkg::cfg_t  cfg,
  input  dss_pkg::req_t  req,
  output logic           done,
  output logic           scan_start,
  output logic [PW-1:0]  scan_pattern,
  output logic [SW-1:0]  scan_step
);

  import dss_pkg::*;

  tm_state_t   state;
  tm_state_t   state_next;
  logic        running;
  logic        ext_clock;
  logic [SW-1:0] cur_step;
  logic [6:0]  tick_cnt;
  logic [3:0]  beat_cnt;
  logic [7:0]  div_cnt;
  logic [PW-1:0] play_pat;
  logic        step_hit;

  logic [4:0]  tps_eff;
  logic [6:0]  tpb_eff;
  logic [4:0]  bpm_eff;
  logic        div_fire;
  logic        is_tick;
  logic        rem_start;
  logic        rem_done;
  logic [7:0]  rem_dividend;
  logic [6:0]  rem_divisor;
  logic [6:0]  rem;
  logic [SW-1:0] step_now;
  logic [4:0]  beat_inc;
  logic [3:0]  beat_wrap;

  assign tps_eff = (cfg.ticks_per_sixteenth == '0) ? 5'd1 : cfg.ticks_per_sixteenth;
  assign tpb_eff = (cfg.beat_ticks == '0) ? 7'd1 : cfg.beat_ticks;
  assign bpm_eff = (cfg.measure_beats == '0) ? 5'd1 : cfg.measure_beats;

  assign div_fire = !ext_clock && running && (div_cnt >= cfg.internal_divide);

  // A step is due when the tick count is a multiple of ticks_per_sixteenth, and the
  // measure restarts at step zero when both tick and beat counts are zero.
  assign step_now  = (beat_cnt == '0 && tick_cnt == '0) ? '0 : cur_step;
  assign beat_inc  = {1'b0, beat_cnt} + 5'd1;
  assign beat_wrap = (beat_inc >= bpm_eff || beat_inc > {1'b0, BEAT_MAX}) ? '0 : beat_inc[3:0];

  always_comb begin
    is_tick = 1'b0;
    if (req.start) begin
      unique case (req.op)
        CMD_TIMER:      is_tick = div_fire;
        CMD_MIDI_CLOCK: is_tick = running && ext_clock;
        default:        is_tick = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next   = state;
    rem_start    = 1'b0;
    rem_dividend = {1'b0, tick_cnt};
    rem_divisor  = {2'b0, tps_eff};
    scan_start   = 1'b0;
    unique case (state)
      TM_IDLE: begin
        if (is_tick) begin
          rem_start  = 1'b1;
          state_next = TM_PHASE;
        end
      end
      TM_PHASE: begin
        rem_dividend = {1'b0, tick_cnt} + 8'd1;
        rem_divisor  = tpb_eff;
        if (rem_done) begin
          rem_start  = 1'b1;
          state_next = TM_WRAP;
        end
      end
      TM_WRAP: begin
        if (rem_done) begin
          scan_start = step_hit;
          state_next = TM_IDLE;
        end
      end
      default: state_next = TM_IDLE;
    endcase
  end

  assign scan_pattern = play_pat;
  assign scan_step    = step_now;

  dss_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      running   <= 1'b0;
      ext_clock <= 1'b0;
      cur_step  <= '0;
      tick_cnt  <= '0;
      beat_cnt  <= '0;
      div_cnt   <= DIVIDE_RST;
      play_pat  <= '0;
      step_hit  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == TM_IDLE && req.start) begin
        done <= !is_tick;
        unique case (req.op)
          CMD_TIMER: begin
            if (div_fire) begin
              div_cnt <= '0;
            end else if (div_cnt != DIVIDER_MAX) begin
              div_cnt <= div_cnt + 8'd1;
            end
          end
          CMD_START: begin
            running   <= 1'b1;
            ext_clock <= 1'b1;
            cur_step  <= '0;
            tick_cnt  <= '0;
            beat_cnt  <= '0;
          end
          CMD_STOP: begin
            running   <= 1'b0;
            ext_clock <= 1'b0;
          end
          CMD_CONTINUE: begin
            running   <= 1'b1;
            ext_clock <= 1'b1;
          end
          CMD_PLAY: begin
            // Play press is ignored while following external clock.
            if (!ext_clock || !running) begin
              running <= !running;
              if (!running) begin
                ext_clock <= 1'b0;
                tick_cnt  <= '0;
                beat_cnt  <= '0;
              end
            end
          end
          CMD_SELECT_PATTERN: begin
            if (32'(req.pattern) < PATTERNS) begin
              play_pat <= PW'(req.pattern);
            end
          end
          CMD_JUMP: begin
            if (32'(req.step) < STEPS) begin
              cur_step <= SW'(req.step);
            end
          end
          default: ;
        endcase
      end
      if (state == TM_PHASE && rem_done) begin
        step_hit <= (rem == '0);
      end
      if (state == TM_WRAP && rem_done) begin
        tick_cnt <= rem;
        if (rem == '0) begin
          beat_cnt <= beat_wrap;
        end
        if (step_hit) begin
          cur_step <= (step_now == SW'(STEPS - 1)) ? '0 : step_now + SW'(1);
        end else begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/dss_store.sv
// Pattern store: step and track-mask memories, edits, clearing pass and step scan.
module dss_store #(
  parameter int PATTERNS = dss_pkg::PATTERNS_DEF,
  parameter int TRACKS   = dss_pkg::TRACKS_DEF,
  parameter int STEPS    = dss_pkg::STEPS_DEF,
  localparam int PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1,
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1,
  localparam int SW = $clog2(STEPS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    chan_cfg,
  input  dss_pkg::req_t req,
  input  logic          scan_start,
  input  logic [PW-1:0] scan_pattern,
  input  logic [SW-1:0] scan_step,
  output logic          done,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [6:0]    note_number,
  output logic [6:0]    note_velocity,
  output logic [3:0]    channel,
  output logic          last
);

  import dss_pkg::*;

  localparam int DEPTH = PATTERNS * TRACKS * STEPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] entry_addr(input logic [PW-1:0] p,
                                               input logic [TW-1:0] t,
                                               input logic [SW-1:0] s);
    return AW'(p) * AW'(TRACKS * STEPS) + AW'(t) * AW'(STEPS) + AW'(s);
  endfunction

  st_state_t     state;
  st_state_t     state_next;
  logic [AW-1:0] clr_cnt;
  logic [TW-1:0] trk;
  logic [PW-1:0] pat_q;
  logic [SW-1:0] step_q;
  req_t          req_q;

  logic          pend_valid;
  logic [6:0]    pend_note;
  logic [6:0]    pend_velo;

  logic          step_we;
  logic [AW-1:0] step_waddr;
  logic [STEP_W-1:0] step_wdata;
  logic [AW-1:0] step_raddr;
  logic [STEP_W-1:0] step_rdata;
  logic          mask_we;
  logic [PW-1:0] mask_waddr;
  logic [TRACKS-1:0] mask_wdata;
  logic [PW-1:0] mask_raddr;
  logic [TRACKS-1:0] mask_rdata;

  logic          trk_last;
  logic          hit;
  logic          out_free;
  logic          advance;
  logic          load_out;
  logic          load_last;
  logic [STEP_W-1:0] toggled;

  assign trk_last = (trk == TW'(TRACKS - 1));
  assign hit      = step_rdata[ENABLE_POS] && mask_rdata[trk];
  assign out_free = !out_valid || !out_stall;
  assign toggled  = step_rdata ^ (STEP_W'(1) << ENABLE_POS);

  always_comb begin
    state_next = state;
    done       = 1'b0;
    step_we    = 1'b0;
    step_waddr = entry_addr(pat_q, TW'(req_q.track), SW'(req_q.step));
    step_wdata = '0;
    step_raddr = entry_addr(pat_q, trk, step_q);
    mask_we    = 1'b0;
    mask_waddr = pat_q;
    mask_wdata = '1;
    mask_raddr = pat_q;
    advance    = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        step_we    = 1'b1;
        step_waddr = clr_cnt;
        mask_we    = (32'(clr_cnt) < PATTERNS);
        mask_waddr = PW'(clr_cnt);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (scan_start) begin
          step_raddr = entry_addr(scan_pattern, '0, scan_step);
          mask_raddr = scan_pattern;
          state_next = ST_SCAN;
        end else begin
          step_raddr = entry_addr(PW'(req.pattern), TW'(req.track), SW'(req.step));
          mask_raddr = PW'(req.pattern);
          if (req.start) begin
            unique case (req.op)
              CMD_TOGGLE_STEP, CMD_SET_VELOCITY: state_next = ST_EDIT;
              CMD_TOGGLE_TRACK:                  state_next = ST_MASK;
              CMD_CLEAR:                         state_next = ST_CLEAR;
              default:                           state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_EDIT: begin
        step_we = 1'b1;
        if (req_q.op == CMD_SET_VELOCITY) begin
          step_wdata = {step_rdata[ENABLE_POS], req_q.velocity};
        end else if (toggled[2:0] == '0) begin
          step_wdata = toggled | {1'b0, DEFAULT_VELOCITY};
        end else begin
          step_wdata = toggled;
        end
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MASK: begin
        mask_we    = 1'b1;
        mask_wdata = mask_rdata ^ (TRACKS'(1) << TW'(req_q.track));
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        // The held note can only be released once the output register is free,
        // so a second hit waits here with the read address held.
        advance  = !(hit && pend_valid && !out_free);
        load_out = hit && pend_valid && out_free;
        if (advance && !trk_last) begin
          step_raddr = entry_addr(pat_q, trk + TW'(1), step_q);
        end
        if (advance && trk_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  dss_ram #(
    .WIDTH (STEP_W),
    .DEPTH (DEPTH)
  ) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (step_waddr),
    .wdata (step_wdata),
    .raddr (step_raddr),
    .rdata (step_rdata)
  );

  dss_ram #(
    .WIDTH (TRACKS),
    .DEPTH (PATTERNS)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      trk        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_IDLE) begin
        clr_cnt    <= '0;
        trk        <= '0;
        pend_valid <= 1'b0;
      end
      if (state == ST_SCAN && advance) begin
        if (!trk_last) begin
          trk <= trk + TW'(1);
        end
        if (hit) begin
          pend_valid <= 1'b1;
        end
      end
      if (state == ST_FLUSH && load_out) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      req_q  <= req;
      pat_q  <= scan_start ? scan_pattern : PW'(req.pattern);
      step_q <= scan_step;
    end
    if (state == ST_SCAN && advance && hit) begin
      pend_note <= note_of(4'(trk));
      pend_velo <= velocity_of(step_rdata[2:0]);
    end
    if (load_out) begin
      note_number   <= pend_note;
      note_velocity <= pend_velo;
      channel       <= chan_cfg;
      last          <= load_last;
    end
  end

endmodule

// File: hw/rtl/drum_step_sequencer_core.sv
// Drum step sequencer core. After reset and after every clear request the block sweeps the
// pattern store, one entry per cycle, PATTERNS * TRACKS * STEPS entries (2048 by default),
// and takes no request meanwhile. Transport, select, jump and edit requests stall the input
// until their unit reports done; unknown commands and edits outside the store do not stall it.
// A clock tick runs the tick count through a bit-serial remainder unit twice; when a step
// falls on that tick the store is then read one track per cycle from its single read port,
// except while a second hit waits for the stalled note output.
// Notes leave through an output register, so the next request is taken while the last
// note of a step is still waiting.
module drum_step_sequencer_core #(
  parameter int PATTERNS = dss_pkg::PATTERNS_DEF,
  parameter int TRACKS   = dss_pkg::TRACKS_DEF,
  parameter int STEPS    = dss_pkg::STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] cmd,
  input  logic [2:0] pattern_sel,
  input  logic [3:0] track_sel,
  input  logic [3:0] step_sel,
  input  logic [2:0] velocity_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] note_number,
  output logic [6:0] note_velocity,
  output logic [3:0] channel,
  output logic       last,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  import dss_pkg::*;

  localparam int PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int SW = $clog2(STEPS);

  cfg_t          cfg;
  logic          busy;
  logic          accept;
  logic          st_go;
  logic          tm_go;
  logic          p_ok;
  logic          t_ok;
  logic          s_ok;
  req_t          req;
  req_t          st_req;
  req_t          tm_req;
  logic          tm_done;
  logic          st_done;
  logic          scan_start;
  logic [PW-1:0] scan_pattern;
  logic [SW-1:0] scan_step;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  assign p_ok = (32'(pattern_sel) < PATTERNS);
  assign t_ok = (32'(track_sel) < TRACKS);
  assign s_ok = (32'(step_sel) < STEPS);

  always_comb begin
    req.start    = 1'b0;
    req.op       = cmd_t'(cmd);
    req.pattern  = pattern_sel;
    req.track    = track_sel;
    req.step     = step_sel;
    req.velocity = velocity_in;
    st_go = 1'b0;
    tm_go = 1'b0;
    // Edits outside the store and unknown commands are dropped without going busy.
    unique case (cmd_t'(cmd))
      CMD_TIMER, CMD_MIDI_CLOCK, CMD_START, CMD_STOP, CMD_CONTINUE, CMD_PLAY,
      CMD_SELECT_PATTERN, CMD_JUMP:      tm_go = 1'b1;
      CMD_TOGGLE_STEP, CMD_SET_VELOCITY: st_go = p_ok && t_ok && s_ok;
      CMD_TOGGLE_TRACK:                  st_go = p_ok && t_ok;
      CMD_CLEAR:                         st_go = 1'b1;
      default: ;
    endcase
    st_req       = req;
    st_req.start = accept && st_go;
    tm_req       = req;
    tm_req.start = accept && tm_go;
  end

  // The store sweeps itself after reset, so the block starts out busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else if (accept && (st_go || tm_go)) begin
      busy <= 1'b1;
    end else if (tm_done || st_done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chan                <= CHANNEL_RST;
      cfg.ticks_per_sixteenth <= TPS_RST;
      cfg.beat_ticks          <= TPB_RST;
      cfg.measure_beats       <= BPM_RST;
      cfg.internal_divide     <= DIVIDE_RST;
    end else if (cfg_write) begin
      unique case (reg_t'(cfg_index))
        REG_CHANNEL:             cfg.chan                <= cfg_data[3:0];
        REG_TICKS_PER_SIXTEENTH: cfg.ticks_per_sixteenth <= cfg_data[4:0];
        REG_BEAT_TICKS:          cfg.beat_ticks          <= cfg_data[6:0];
        REG_MEASURE_BEATS:       cfg.measure_beats       <= cfg_data[4:0];
        REG_INTERNAL_DIVIDE:     cfg.internal_divide     <= cfg_data;
        default: ;
      endcase
    end
  end

  dss_timing #(
    .PATTERNS (PATTERNS),
    .STEPS    (STEPS)
  ) u_timing (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req          (tm_req),
    .done         (tm_done),
    .scan_start   (scan_start),
    .scan_pattern (scan_pattern),
    .scan_step    (scan_step)
  );

  dss_store #(
    .PATTERNS (PATTERNS),
    .TRACKS   (TRACKS),
    .STEPS    (STEPS)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .chan_cfg      (cfg.chan),
    .req           (st_req),
    .scan_start    (scan_start),
    .scan_pattern  (scan_pattern),
    .scan_step     (scan_step),
    .done          (st_done),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .channel       (channel),
    .last          (last)
  );

endmodule

// File: tb/sv/drum_step_sequencer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the drum step sequencer core with its own note predictor.
module drum_step_sequencer_core_tb;
  import dss_pkg::*;

  localparam logic [3:0] CMD_UNKNOWN_FIRST = 4'd12;
  localparam logic [3:0] CMD_UNKNOWN_LAST  = 4'd15;
  // Covers a clear sweep of the whole store plus the longest tick.
  localparam int SETTLE_CYCLES = 2200;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [6:0] number;
    logic [6:0] velocity;
    logic [3:0] chan;
    logic       final_note;
  } note_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] cmd = CMD_TIMER;
  logic [2:0] pattern_sel = 3'd0;
  logic [3:0] track_sel = 4'd0;
  logic [3:0] step_sel = 4'd0;
  logic [2:0] velocity_in = 3'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] note_number;
  logic [6:0] note_velocity;
  logic [3:0] channel;
  logic       last;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = REG_CHANNEL;
  logic [7:0] cfg_data = 8'd0;

  // Predicted sequencer state.
  logic [3:0]  pattern_entries [PATTERNS_DEF][TRACKS_DEF][STEPS_DEF];
  logic [15:0] track_enables [PATTERNS_DEF];
  logic        seq_running;
  logic        seq_external;
  logic [3:0]  seq_step;
  logic [6:0]  seq_tick;
  logic [3:0]  seq_beat;
  logic [7:0]  seq_divider;
  logic [2:0]  seq_pattern;
  logic [3:0]  cfg_channel;
  logic [4:0]  cfg_tps;
  logic [6:0]  cfg_tpb;
  logic [4:0]  cfg_bpm;
  logic [7:0]  cfg_divide;

  logic [6:0] track_note [TRACKS_DEF] = '{7'd49, 7'd37, 7'd39, 7'd51, 7'd42, 7'd44, 7'd46,
                                          7'd50, 7'd36, 7'd38, 7'd40, 7'd41, 7'd43, 7'd45,
                                          7'd47, 7'd48};

  note_t expected_notes [$];
  note_t want_note;
  int    mismatches = 0;
  int    hold_cycles = 0;
  bit    steady = 1'b0;

  drum_step_sequencer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .pattern_sel(pattern_sel), .track_sel(track_sel),
    .step_sel(step_sel), .velocity_in(velocity_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .note_number(note_number), .note_velocity(note_velocity),
    .channel(channel), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic void clear_entries();
    for (int p = 0; p < PATTERNS_DEF; p++) begin
      track_enables[p] = '1;
      for (int t = 0; t < TRACKS_DEF; t++)
        for (int s = 0; s < STEPS_DEF; s++)
          pattern_entries[p][t][s] = 4'd0;
    end
  endfunction

  function automatic void reset_sequencer_model();
    clear_entries();
    seq_running = 1'b0;
    seq_external = 1'b0;
    seq_step = 4'd0;
    seq_tick = 7'd0;
    seq_beat = 4'd0;
    seq_divider = DIVIDE_RST;
    seq_pattern = 3'd0;
    cfg_channel = CHANNEL_RST;
    cfg_tps = TPS_RST;
    cfg_tpb = TPB_RST;
    cfg_bpm = BPM_RST;
    cfg_divide = DIVIDE_RST;
  endfunction

  function automatic bit track_sounds(input int trk);
    return pattern_entries[seq_pattern][trk][seq_step][ENABLE_POS] &&
           track_enables[seq_pattern][trk];
  endfunction

  // One clock tick: on a sixteenth, queue the notes of the current step in track order.
  function automatic void advance_clock();
    int unsigned tps, tpb, bpm, next_beat, vel;
    int last_trk;
    note_t note;
    if (!seq_running) return;
    tps = (cfg_tps == 0) ? 1 : cfg_tps;
    tpb = (cfg_tpb == 0) ? 1 : cfg_tpb;
    bpm = (cfg_bpm == 0) ? 1 : cfg_bpm;
    if (seq_tick % tps == 0) begin
      if (seq_beat == 0 && seq_tick == 0) seq_step = 4'd0;
      last_trk = -1;
      for (int trk = 0; trk < TRACKS_DEF; trk++)
        if (track_sounds(trk)) last_trk = trk;
      for (int trk = 0; trk < TRACKS_DEF; trk++) begin
        if (track_sounds(trk)) begin
          vel = pattern_entries[seq_pattern][trk][seq_step][2:0] * VELO_SCALE + 1;
          if (vel > VELO_MAX) vel = VELO_MAX;
          note.number = track_note[trk];
          note.velocity = 7'(vel);
          note.chan = cfg_channel;
          note.final_note = (trk == last_trk);
          expected_notes.push_back(note);
        end
      end
      seq_step = seq_step + 4'd1;
    end
    seq_tick = 7'((seq_tick + 1) % tpb);
    if (seq_tick == 0) begin
      next_beat = seq_beat + 1;
      if (next_beat >= bpm || next_beat > BEAT_MAX) next_beat = 0;
      seq_beat = 4'(next_beat);
    end
  endfunction

  function automatic void predict_request(input logic [3:0] op, input logic [2:0] pat,
                                          input logic [3:0] trk, input logic [3:0] stp,
                                          input logic [2:0] vel);
    logic [3:0] entry;
    case (op)
      CMD_TIMER: begin
        if (!seq_external && seq_running && seq_divider >= cfg_divide) begin
          seq_divider = 8'd0;
          advance_clock();
        end else if (seq_divider < DIVIDER_MAX) begin
          seq_divider = seq_divider + 8'd1;
        end
      end
      CMD_MIDI_CLOCK: if (seq_running && seq_external) advance_clock();
      CMD_START: begin
        seq_running = 1'b1;
        seq_external = 1'b1;
        seq_step = 4'd0;
        seq_tick = 7'd0;
        seq_beat = 4'd0;
      end
      CMD_STOP: begin
        seq_running = 1'b0;
        seq_external = 1'b0;
      end
      CMD_CONTINUE: begin
        seq_running = 1'b1;
        seq_external = 1'b1;
      end
      CMD_PLAY: begin
        if (!seq_external || !seq_running) begin
          seq_running = !seq_running;
          if (seq_running) begin
            seq_external = 1'b0;
            seq_tick = 7'd0;
            seq_beat = 4'd0;
          end
        end
      end
      CMD_TOGGLE_STEP: begin
        entry = pattern_entries[pat][trk][stp];
        entry[ENABLE_POS] = !entry[ENABLE_POS];
        if (entry[2:0] == 3'd0) entry[2:0] = DEFAULT_VELOCITY;
        pattern_entries[pat][trk][stp] = entry;
      end
      CMD_SET_VELOCITY: pattern_entries[pat][trk][stp][2:0] = vel;
      CMD_TOGGLE_TRACK: track_enables[pat][trk] = !track_enables[pat][trk];
      CMD_SELECT_PATTERN: seq_pattern = pat;
      CMD_JUMP: seq_step = stp;
      CMD_CLEAR: clear_entries();
      default: ;
    endcase
  endfunction

  task automatic send_req(input logic [3:0] op, input logic [2:0] pat, input logic [3:0] trk,
                          input logic [3:0] stp, input logic [2:0] vel);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    pattern_sel <= pat;
    track_sel <= trk;
    step_sel <= stp;
    velocity_in <= vel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, pat, trk, stp, vel);
  endtask

  task automatic write_register(input reg_t idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_CHANNEL:             cfg_channel = value[3:0];
      REG_TICKS_PER_SIXTEENTH: cfg_tps = value[4:0];
      REG_BEAT_TICKS:          cfg_tpb = value[6:0];
      REG_MEASURE_BEATS:       cfg_bpm = value[4:0];
      REG_INTERNAL_DIVIDE:     cfg_divide = value;
      default: ;
    endcase
  endtask

  task automatic write_registers(input logic [7:0] chan, input logic [7:0] tps,
                                 input logic [7:0] tpb, input logic [7:0] bpm,
                                 input logic [7:0] divide);
    write_register(REG_CHANNEL, chan);
    write_register(REG_TICKS_PER_SIXTEENTH, tps);
    write_register(REG_BEAT_TICKS, tpb);
    write_register(REG_MEASURE_BEATS, bpm);
    write_register(REG_INTERNAL_DIVIDE, divide);
    cfg_write <= 1'b0;
  endtask

  task automatic drain_notes();
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly running traffic: clock ticks of the active source mixed with edits on the
  // pattern that is playing, plus transport changes, stray commands and rare clears.
  task automatic send_random(input int unsigned count);
    int unsigned pick;
    logic [2:0] pat;
    logic [3:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      pat = ($urandom_range(4) == 0) ? 3'($urandom) : seq_pattern;
      if (!seq_running && $urandom_range(2) != 0) begin
        case ($urandom_range(2))
          0: op = CMD_START;
          1: op = CMD_CONTINUE;
          default: op = CMD_PLAY;
        endcase
      end else if (pick < 45) begin
        if (seq_external) op = (pick < 42) ? CMD_MIDI_CLOCK : CMD_TIMER;
        else op = (pick < 42) ? CMD_TIMER : CMD_MIDI_CLOCK;
      end else if (pick < 70) begin
        op = CMD_TOGGLE_STEP;
      end else if (pick < 78) begin
        op = CMD_SET_VELOCITY;
      end else if (pick < 82) begin
        op = CMD_TOGGLE_TRACK;
      end else if (pick < 85) begin
        op = CMD_SELECT_PATTERN;
      end else if (pick < 89) begin
        op = CMD_JUMP;
      end else if (pick < 95) begin
        case ($urandom_range(3))
          0: op = CMD_START;
          1: op = CMD_STOP;
          2: op = CMD_CONTINUE;
          default: op = CMD_PLAY;
        endcase
      end else if (pick < 98) begin
        op = 4'($urandom_range(CMD_UNKNOWN_LAST, CMD_UNKNOWN_FIRST));
      end else if (pick < 99) begin
        op = CMD_CLEAR;
      end else begin
        op = CMD_TIMER;
      end
      send_req(op, pat, 4'($urandom), 4'($urandom), 3'($urandom));
    end
  endtask

  // Fills the playing pattern with some steps first so that the ticks have notes to play.
  task automatic play_random_phase(input int unsigned count);
    for (int i = 0; i < 16; i++)
      send_req(CMD_TOGGLE_STEP, seq_pattern, 4'($urandom), 4'($urandom), 3'($urandom));
    send_random(count - 16);
    drain_notes();
  endtask

  task automatic test_directed_commands();
    write_registers(8'd15, 8'd1, 8'd4, 8'd2, 8'd1);
    send_req(CMD_TOGGLE_STEP, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_TOGGLE_STEP, 3'd0, 4'd15, 4'd0, 3'd7);
    send_req(CMD_SET_VELOCITY, 3'd0, 4'd15, 4'd0, 3'd7);
    send_req(CMD_TOGGLE_STEP, 3'd0, 4'd3, 4'd1, 3'd0);
    send_req(CMD_SET_VELOCITY, 3'd0, 4'd3, 4'd1, 3'd0);
    send_req(CMD_TOGGLE_STEP, 3'd7, 4'd8, 4'd15, 3'd0);
    send_req(CMD_SET_VELOCITY, 3'd7, 4'd8, 4'd15, 3'd3);
    send_req(CMD_TOGGLE_TRACK, 3'd0, 4'd15, 4'd0, 3'd0);
    send_req(CMD_UNKNOWN_FIRST, 3'd7, 4'd15, 4'd15, 3'd7);
    send_req(CMD_START, 3'd0, 4'd0, 4'd0, 3'd0);
    // A play press is ignored while running from external clock.
    send_req(CMD_PLAY, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_MIDI_CLOCK, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_TIMER, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_MIDI_CLOCK, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_TOGGLE_TRACK, 3'd0, 4'd15, 4'd0, 3'd0);
    send_req(CMD_JUMP, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_MIDI_CLOCK, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_SELECT_PATTERN, 3'd7, 4'd0, 4'd0, 3'd0);
    send_req(CMD_JUMP, 3'd0, 4'd0, 4'd15, 3'd0);
    send_req(CMD_MIDI_CLOCK, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_MIDI_CLOCK, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_STOP, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_PLAY, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_TIMER, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_CLEAR, 3'd0, 4'd0, 4'd0, 3'd0);
    send_req(CMD_PLAY, 3'd0, 4'd0, 4'd0, 3'd0);
    drain_notes();
  endtask

  task automatic test_single_tick_measure();
    write_registers(8'd0, 8'd1, 8'd1, 8'd1, 8'd0);
    play_random_phase(85);
  endtask

  task automatic test_long_measure();
    // Twenty beats per measure is more than the beat counter holds.
    write_registers(8'd9, 8'd2, 8'd8, 8'd20, 8'd2);
    play_random_phase(85);
  endtask

  task automatic test_zero_timing();
    write_registers(8'd5, 8'd0, 8'd0, 8'd0, 8'd1);
    play_random_phase(85);
  endtask

  task automatic test_slowest_settings();
    write_registers(8'd15, 8'd24, 8'd96, 8'd16, 8'd255);
    play_random_phase(50);
  endtask

  task automatic test_unbroken_flow();
    steady = 1'b1;
    write_registers(8'd12, 8'd3, 8'd12, 8'd4, 8'd3);
    play_random_phase(85);
    steady = 1'b0;
  endtask

  // Full steps queue up behind a long receiver hold-off until the input stalls.
  task automatic test_back_pressure();
    write_registers(8'd7, 8'd1, 8'd16, 8'd4, 8'd1);
    send_req(CMD_SELECT_PATTERN, 3'd1, 4'd0, 4'd0, 3'd0);
    for (int trk = 0; trk < TRACKS_DEF; trk++)
      send_req(CMD_TOGGLE_STEP, 3'd1, 4'(trk), 4'd0, 3'($urandom));
    send_req(CMD_START, 3'd0, 4'd0, 4'd0, 3'd0);
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (6) begin
      send_req(CMD_JUMP, 3'd0, 4'd0, 4'd0, 3'd0);
      send_req(CMD_MIDI_CLOCK, 3'd0, 4'd0, 4'd0, 3'd0);
    end
    drain_notes();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_notes.size() == 0) begin
        report_mismatch($sformatf("unexpected note %0d vel %0d ch %0d last %0b",
                                  note_number, note_velocity, channel, last));
      end else begin
        want_note = expected_notes.pop_front();
        if (note_number !== want_note.number || note_velocity !== want_note.velocity ||
            channel !== want_note.chan || last !== want_note.final_note)
          report_mismatch($sformatf(
            "note %0d vel %0d ch %0d last %0b, wanted %0d vel %0d ch %0d last %0b",
            note_number, note_velocity, channel, last, want_note.number,
            want_note.velocity, want_note.chan, want_note.final_note));
      end
    end
  end

  initial begin
    reset_sequencer_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_single_tick_measure();
    test_long_measure();
    test_zero_timing();
    test_slowest_settings();
    test_unbroken_flow();
    test_back_pressure();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: drum_step_sequencer_core.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_ram.sv
hw/rtl/dss_rem.sv
hw/rtl/dss_timing.sv
hw/rtl/dss_store.sv
hw/rtl/drum_step_sequencer_core.sv
tb/sv/drum_step_sequencer_core_tb.sv
